// ===== hdl/pctsel_pkg.sv =====
// shared types and constants of the percentile selection block
package pctsel_pkg;

	localparam int SAMPLE_W        = 16;
	localparam int PCT_W           = 17;
	localparam int MAX_SAMPLES_DEF = 256;
	localparam logic [PCT_W-1:0] PCT_RESET = 17'd32768;

	// one input item
	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                last;
	} smp_item_t;

	// one result item
	typedef struct packed {
		logic [SAMPLE_W-1:0] selected;
		logic                overflow;
	} res_item_t;

	// control of the rank counting unit
	typedef struct packed {
		logic clear;
		logic en;
	} cnt_ctl_t;

endpackage

// ===== hdl/percentile_select.sv =====
// percentile selection over a set of samples held in ram
//
// Samples enter on the smp channel, one item per cycle, with last set on the
// final item of a set. Up to MAX_SAMPLES samples are written to the sample
// ram; later ones are dropped and flag overflow in the result. After the last
// item smp_stall stays high while the selection pass runs: the rank
// round(n * percentile) is formed in the states ST_MUL and ST_CLAMP (multiply,
// round and clamp), then each candidate i = 0, 1, ... is read and compared
// against all n stored samples through the single ram read port, until the
// candidate whose rank span covers the wanted rank is found. The result is
// held in an output register on the res channel; while the receiver stalls
// it, a new set is collected, and only the step that loads the next result
// waits for the register to drain. Reset clears the sample count, the
// overflow flag and the result valid, sets the percentile to one half and
// leaves the ram contents undefined; no clearing pass is needed.
// cfg_we writes cfg_data (Q1.16) to the percentile and must be used only while idle.
module percentile_select #(
	parameter int MAX_SAMPLES = pctsel_pkg::MAX_SAMPLES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          smp_valid,
	output logic                          smp_stall,
	input  pctsel_pkg::smp_item_t         smp_item,
	output logic                          res_valid,
	input  logic                          res_stall,
	output pctsel_pkg::res_item_t         res_item,
	input  logic                          cfg_we,
	input  logic [pctsel_pkg::PCT_W-1:0]  cfg_data
);

	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int ADDR_W = $clog2(MAX_SAMPLES);
	localparam int PROD_W = CNT_W + pctsel_pkg::PCT_W;
	localparam int RANK_W = PROD_W - 15;

	typedef enum logic [8:0] {
		ST_COLLECT = 9'b000000001,
		ST_MUL     = 9'b000000010,
		ST_CLAMP   = 9'b000000100,
		ST_CAND_RD = 9'b000001000,
		ST_CAND_WT = 9'b000010000,
		ST_SCAN    = 9'b000100000,
		ST_DRAIN   = 9'b001000000,
		ST_CHECK   = 9'b010000000,
		ST_DONE    = 9'b100000000
	} state_t;

	state_t                              state_q;
	logic [pctsel_pkg::PCT_W-1:0]        pct_q;
	logic [CNT_W-1:0]                    count_q;
	logic                                ovf_q;
	logic [CNT_W-1:0]                    n_q;
	logic                                set_ovf_q;
	logic [PROD_W-1:0]                   prod_q;
	logic [CNT_W-1:0]                    rank_q;
	logic [CNT_W-1:0]                    cand_q;
	logic [CNT_W-1:0]                    j_q;
	logic [pctsel_pkg::SAMPLE_W-1:0]     cand_val_q;
	logic                                rd_vld_s1;
	logic                                res_valid_q;
	pctsel_pkg::res_item_t               res_item_q;

	logic                                smp_acc;
	logic                                room;
	logic                                ram_we;
	logic [ADDR_W-1:0]                   ram_raddr;
	logic [pctsel_pkg::SAMPLE_W-1:0]     ram_rdata;
	logic [PROD_W:0]                     rnd_sum;
	logic [RANK_W-1:0]                   rank_full;
	logic [CNT_W-1:0]                    rank_clamped;
	logic [CNT_W-1:0]                    lt_cnt;
	logic [CNT_W-1:0]                    le_cnt;
	logic                                hit;
	logic                                res_load;
	pctsel_pkg::cnt_ctl_t                cnt_ctl;

	// handshake and store decode
	assign smp_stall = (state_q != ST_COLLECT);
	assign smp_acc   = smp_valid && !smp_stall;
	assign room      = (count_q < CNT_W'(MAX_SAMPLES));
	assign ram_we    = smp_acc && room;
	assign ram_raddr = (state_q == ST_SCAN) ? j_q[ADDR_W-1:0] : cand_q[ADDR_W-1:0];

	// rounding and clamping of the rank
	assign rnd_sum   = {1'b0, prod_q} + (PROD_W + 1)'(32768);
	assign rank_full = rnd_sum[PROD_W:16];
	assign rank_clamped = (rank_full >= RANK_W'(n_q)) ? (n_q - CNT_W'(1))
	                                                  : rank_full[CNT_W-1:0];

	// candidate covers the wanted rank
	assign hit      = (lt_cnt <= rank_q) && (rank_q < le_cnt);
	assign res_load = (state_q == ST_DONE) && (!res_valid_q || !res_stall);

	assign cnt_ctl.clear = (state_q == ST_CAND_WT);
	assign cnt_ctl.en    = rd_vld_s1;

	pctsel_ram #(
		.WIDTH(pctsel_pkg::SAMPLE_W),
		.DEPTH(MAX_SAMPLES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (smp_item.sample),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	pctsel_count #(
		.CNT_W(CNT_W)
	) u_count (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cnt_ctl),
		.sample (ram_rdata),
		.cand   (cand_val_q),
		.lt     (lt_cnt),
		.le     (le_cnt)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pct_q <= pctsel_pkg::PCT_RESET;
		end else if (cfg_we) begin
			pct_q <= cfg_data;
		end
	end

	// collection and selection sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_COLLECT;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			n_q       <= '0;
			set_ovf_q <= 1'b0;
			rank_q    <= '0;
			cand_q    <= '0;
			j_q       <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			case (state_q)
				ST_COLLECT: begin
					if (smp_acc) begin
						if (smp_item.last) begin
							n_q       <= room ? (count_q + CNT_W'(1)) : count_q;
							set_ovf_q <= ovf_q || !room;
							count_q   <= '0;
							ovf_q     <= 1'b0;
							state_q   <= ST_MUL;
						end else if (room) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					rank_q  <= rank_clamped;
					cand_q  <= '0;
					state_q <= ST_CAND_RD;
				end
				ST_CAND_RD: begin
					state_q <= ST_CAND_WT;
				end
				ST_CAND_WT: begin
					j_q     <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					j_q <= j_q + CNT_W'(1);
					if (j_q == n_q - CNT_W'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (hit) begin
						state_q <= ST_DONE;
					end else begin
						cand_q  <= cand_q + CNT_W'(1);
						state_q <= ST_CAND_RD;
					end
				end
				ST_DONE: begin
					if (res_load) begin
						state_q <= ST_COLLECT;
					end
				end
				default: begin
					state_q <= ST_COLLECT;
				end
			endcase
		end
	end

	// product, candidate and result data registers
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			prod_q <= PROD_W'(n_q) * PROD_W'(pct_q);
		end
		if (state_q == ST_CAND_WT) begin
			cand_val_q <= ram_rdata;
		end
		if (res_load) begin
			res_item_q.selected <= cand_val_q;
			res_item_q.overflow <= set_ovf_q;
		end
	end

	// result output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

`ifndef SYNTH
	// sample count never passes the capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_SAMPLES))
		else $error("sample count beyond capacity");

	// clamped rank lies inside the set during the search
	a_rank_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CAND_RD) |-> (rank_q < n_q))
		else $error("rank outside the set");

	// the search finds a candidate before running out of samples
	a_cand_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CAND_RD) |-> (cand_q < n_q))
		else $error("candidate search ran past the set");

	// counts after a full scan are consistent with the set size
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> ((lt_cnt <= le_cnt) && (le_cnt <= n_q)
		&& (le_cnt != '0)))
		else $error("inconsistent rank counts");

	// a loaded result is presented next cycle and collection resumes
	a_res_load: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> (res_valid_q && (state_q == ST_COLLECT)))
		else $error("result load lost");
`endif

endmodule

// ===== hdl/pctsel_ram.sv =====
// generic simple dual port ram with registered read
module pctsel_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/pctsel_count.sv =====
// counts stored samples below and not above the current candidate
module pctsel_count #(
	parameter int CNT_W = 9
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pctsel_pkg::cnt_ctl_t          ctl,
	input  logic [pctsel_pkg::SAMPLE_W-1:0] sample,
	input  logic [pctsel_pkg::SAMPLE_W-1:0] cand,
	output logic [CNT_W-1:0]              lt,
	output logic [CNT_W-1:0]              le
);

	logic [CNT_W-1:0] lt_q;
	logic [CNT_W-1:0] le_q;

	// accumulate one compared sample per cycle while ctl.en is set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= '0;
			le_q <= '0;
		end else if (ctl.clear) begin
			lt_q <= '0;
			le_q <= '0;
		end else if (ctl.en) begin
			if (sample < cand) begin
				lt_q <= lt_q + CNT_W'(1);
			end
			if (sample <= cand) begin
				le_q <= le_q + CNT_W'(1);
			end
		end
	end

	assign lt = lt_q;
	assign le = le_q;

endmodule
